// ===== rtl/core/u16u8_pkg.sv =====
// u16u8_pkg: shared types, mode codes and the UTF-8 encode function
// for the UTF-16 / 8-bit to UTF-8 transcoder. No dependencies.
`default_nettype none

package u16u8_pkg;

  typedef enum logic [1:0] {
    MODE_UTF16LE  = 2'd0,
    MODE_UTF16BE  = 2'd1,
    MODE_EIGHTBIT = 2'd2,
    MODE_PASS     = 2'd3
  } mode_e;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = 3;
  localparam int unsigned CpW      = 21;

  localparam logic [15:0]    HighFirst  = 16'hD800;
  localparam logic [15:0]    HighLast   = 16'hDBFF;
  // 0x10000 - 0xDC00, folded into one constant for the pair join
  localparam logic [CpW-1:0] PairOffset = 21'h10000 - 21'h0DC00;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [CntW-1:0]          cnt;
  } enc_t;

  function automatic logic is_high(logic [15:0] u);
    return (u >= HighFirst) && (u <= HighLast);
  endfunction

  function automatic enc_t encode_cp(logic [CpW-1:0] cp);
    enc_t r;
    r.data = '0;
    if (cp < 21'h80) begin
      r.cnt     = 3'd1;
      r.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.cnt     = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.cnt     = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt     = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u16u8_intf.sv =====
// Valid/ready channel interfaces for the transcoder: source bytes in,
// UTF-8 words out. No dependencies.
`default_nettype none

interface u16u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u16u8_encoder.sv =====
// u16u8_encoder: mode register, unit pairing / surrogate state and the
// combinational UTF-8 encode of one source word. Uses u16u8_pkg.
`default_nettype none

module u16u8_encoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_data_i,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output u16u8_pkg::enc_t      enc_o
);

  u16u8_pkg::mode_e mode_q;
  logic [7:0]  held_q, held_d;
  logic        held_vld_q, held_vld_d;
  logic [15:0] pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;

  logic [15:0]                   unit;
  logic [u16u8_pkg::CpW-1:0]     pair_cp;
  u16u8_pkg::enc_t               enc;

  assign unit = (mode_q == u16u8_pkg::MODE_UTF16BE) ? {held_q, byte_i} : {byte_i, held_q};
  assign pair_cp = {1'b0, pend_q[9:0], 10'b0} + {5'b0, unit} + u16u8_pkg::PairOffset;

  always_comb begin
    enc        = '0;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    unique case (mode_q)
      u16u8_pkg::MODE_UTF16LE, u16u8_pkg::MODE_UTF16BE: begin
        if (!held_vld_q) begin
          if (last_i) begin
            if (pend_vld_q) begin
              enc = u16u8_pkg::encode_cp({5'b0, pend_q});
            end
          end else begin
            held_d     = byte_i;
            held_vld_d = 1'b1;
          end
        end else begin
          held_d     = '0;
          held_vld_d = 1'b0;
          if (pend_vld_q) begin
            enc        = u16u8_pkg::encode_cp(pair_cp);
            pend_d     = '0;
            pend_vld_d = 1'b0;
          end else if (u16u8_pkg::is_high(unit) && !last_i) begin
            pend_d     = unit;
            pend_vld_d = 1'b1;
          end else begin
            enc = u16u8_pkg::encode_cp({5'b0, unit});
          end
        end
      end
      u16u8_pkg::MODE_EIGHTBIT: begin
        enc = u16u8_pkg::encode_cp({13'b0, byte_i});
      end
      u16u8_pkg::MODE_PASS: begin
        enc.cnt     = 3'd1;
        enc.data[0] = byte_i;
      end
      default: enc = '0;
    endcase
    if (last_i) begin
      held_d     = '0;
      held_vld_d = 1'b0;
      pend_d     = '0;
      pend_vld_d = 1'b0;
    end
  end

  assign enc_o = enc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= u16u8_pkg::MODE_UTF16LE;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q     <= u16u8_pkg::mode_e'(cfg_data_i);
      held_q     <= '0;
      held_vld_q <= 1'b0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else if (accept_i) begin
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u16u8_out_buf.sv =====
// u16u8_out_buf: result register holding up to four UTF-8 bytes of one
// source word, sent out one word per cycle while ready. Uses u16u8_pkg.
`default_nettype none

module u16u8_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  u16u8_pkg::enc_t      enc_i,
  output logic                 can_load_o,
  u16u8_out_if.source          out_o
);

  logic [u16u8_pkg::MaxBytes-1:0][7:0] data_q;
  logic [u16u8_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic [1:0]                          idx_q, idx_d;
  logic                                pop;

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = data_q[idx_q];
  assign out_o.run_last = (cnt_q == 3'd1);
  assign pop            = out_o.valid && out_o.ready;
  assign can_load_o     = (cnt_q == '0) || ((cnt_q == 3'd1) && out_o.ready);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = enc_i.cnt;
      idx_d = '0;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= enc_i.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// utf16_to_utf8_transcoder: top level, source bytes in, UTF-8 words out.
// Uses u16u8_pkg, u16u8_intf, u16u8_encoder, u16u8_out_buf.
//
// Usage:
// - in_i carries one source byte per word plus end_of_text on the final
//   byte of a text; out_o carries UTF-8 words, run_last on the last word
//   produced by one source byte.
// - cfg_we_i/cfg_data_i write source_mode (0 UTF-16 LE, 1 UTF-16 BE,
//   2 eight-bit, 3 pass through); a write drops any half unit and any
//   held high surrogate. Write only while idle.
// - Latency: the first UTF-8 word of a source byte is valid the cycle
//   after the byte is accepted. A byte producing no words leaves nothing.
// - Throughput: one source byte per cycle while each yields at most one
//   word and the receiver is ready; a byte yielding more words holds the
//   result register until its last word is taken, and the register is
//   reloaded in the same cycle its last word is taken.
// - Reset: mode UTF-16 LE, no held byte, no pending surrogate, output
//   empty.
// - Receiver stall: the current word holds and in_i.ready drops once the
//   result register cannot take a new byte.
`default_nettype none

module utf16_to_utf8_transcoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  u16u8_in_if.sink        in_i,
  u16u8_out_if.source     out_o
);

  logic            accept;
  logic            can_load;
  u16u8_pkg::enc_t enc;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  u16u8_encoder u_encoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .byte_i     (in_i.in_byte),
    .last_i     (in_i.end_of_text),
    .enc_o      (enc)
  );

  u16u8_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .enc_i      (enc),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/u16u8_transcode_checker.sv =====
`timescale 1ns / 1ps
// u16u8_transcode_checker: watches the transcoder's byte and UTF-8 channels,
// predicts every UTF-8 word from the source mode and bytes, checks in order.
// Depends on u16u8_pkg and u16u8_intf.
module u16u8_transcode_checker
  import u16u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  u16u8_in_if        in_w,
  u16u8_out_if       out_w,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } utf8_word_t;

  utf8_word_t  utf8_bytes_q[$];
  mode_e       src_mode;
  logic [7:0]  half_byte;
  logic        half_valid;
  logic [15:0] high_unit;
  logic        high_valid;
  int          fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_text();
    half_byte  = '0;
    half_valid = 1'b0;
    high_unit  = '0;
    high_valid = 1'b0;
  endtask

  task automatic push_utf8(input logic [7:0] b);
    utf8_word_t w;
    w.out_byte   = b;
    w.run_last   = 1'b0;
    utf8_bytes_q = {utf8_bytes_q, w};
  endtask

  task automatic encode_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_utf8(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_utf8(8'hC0 | 8'(cp >> 6));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      push_utf8(8'hE0 | 8'(cp >> 12));
      push_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end else begin
      push_utf8(8'hF0 | 8'(cp >> 18));
      push_utf8(8'h80 | 8'((cp >> 12) & 21'h3F));
      push_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end
  endtask

  task automatic transcode_utf16(input logic [7:0] b, input logic eot, input logic big);
    logic [15:0] unit_v;
    logic [20:0] cp;
    if (!half_valid) begin
      if (eot) begin
        // odd trailing byte dropped; a waiting high surrogate goes out alone
        if (high_valid) encode_utf8({5'b0, high_unit});
        clear_text();
      end else begin
        half_byte  = b;
        half_valid = 1'b1;
      end
      return;
    end
    unit_v     = big ? {half_byte, b} : {b, half_byte};
    half_byte  = '0;
    half_valid = 1'b0;
    if (high_valid) begin
      // joined without checking the second unit, modulo 2^21
      cp = 21'h10000 + (({5'b0, high_unit} - 21'h0D800) << 10)
         + {5'b0, unit_v} - 21'h0DC00;
      high_unit  = '0;
      high_valid = 1'b0;
      encode_utf8(cp);
    end else if (unit_v >= 16'hD800 && unit_v <= 16'hDBFF && !eot) begin
      high_unit  = unit_v;
      high_valid = 1'b1;
    end else begin
      encode_utf8({5'b0, unit_v});
    end
    if (eot) clear_text();
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic eot);
    int first;
    first = utf8_bytes_q.size();
    case (src_mode)
      MODE_UTF16LE: transcode_utf16(b, eot, 1'b0);
      MODE_UTF16BE: transcode_utf16(b, eot, 1'b1);
      MODE_EIGHTBIT: begin
        if (b < 8'h80) begin
          push_utf8(b);
        end else begin
          push_utf8(8'hC0 | (b >> 6));
          push_utf8(8'h80 | (b & 8'h3F));
        end
        if (eot) clear_text();
      end
      default: begin
        push_utf8(b);
        if (eot) clear_text();
      end
    endcase
    if (utf8_bytes_q.size() > first) utf8_bytes_q[$].run_last = 1'b1;
  endtask

  task automatic check_word();
    utf8_word_t exp_w;
    if (utf8_bytes_q.size() == 0) begin
      report_mismatch($sformatf("word %02h run_last %0b with none expected",
                                out_w.out_byte, out_w.run_last));
      return;
    end
    exp_w = utf8_bytes_q.pop_front();
    if (out_w.out_byte !== exp_w.out_byte)
      report_mismatch($sformatf("out_byte %02h, expected %02h",
                                out_w.out_byte, exp_w.out_byte));
    if (out_w.run_last !== exp_w.run_last)
      report_mismatch($sformatf("run_last %0b, expected %0b (out_byte %02h)",
                                out_w.run_last, exp_w.run_last, exp_w.out_byte));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_mode = MODE_UTF16LE;
      clear_text();
      utf8_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (out_w.valid && out_w.ready) check_word();
      if (cfg_we_i) begin
        src_mode = mode_e'(cfg_data_i);
        clear_text();
      end
      if (in_w.valid && in_w.ready) transcode_byte(in_w.in_byte, in_w.end_of_text);
      pending_o <= utf8_bytes_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset, mode writes and source byte stimulus for the
// UTF-16 / 8-bit to UTF-8 transcoder. Uses u16u8_pkg, u16u8_intf, the checker.
module tb_top;
  import u16u8_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int          PhaseBytes = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_data_i;
  int          tx_idle_pct = 26;
  int          rx_idle_pct = 59;
  logic        hold_req = 1'b0;
  int          bytes_sent = 0;
  int          fail_count;
  int          pending_words;
  int unsigned cycles = 0;

  u16u8_in_if  in_w ();
  u16u8_out_if out_w ();

  utf16_to_utf8_transcoder dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_w),
    .out_o     (out_w)
  );

  u16u8_transcode_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_w        (in_w),
    .out_w       (out_w),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_w.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid       <= 1'b1;
    in_w.in_byte     <= b;
    in_w.end_of_text <= eot;
    do @(posedge clk_i); while (in_w.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) send_word(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic utf16_text(input logic big);
    logic [15:0] units[$];
    logic [7:0]  txt[$];
    int          n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: units = {units, 16'($urandom_range(16'h7F))};
        1: units = {units, 16'($urandom_range(16'h7FF, 16'h80))};
        2: units = {units, 16'($urandom_range(16'hFFFF, 16'h800))};
        3: begin
          units = {units, 16'($urandom_range(16'hDBFF, 16'hD800))};
          units = {units, 16'($urandom_range(16'hDFFF, 16'hDC00))};
        end
        4: units = {units, 16'($urandom_range(16'hDBFF, 16'hD800))};
        default: units = {units, 16'($urandom)};
      endcase
    end
    foreach (units[i]) begin
      if (big) begin
        txt = {txt, units[i][15:8]};
        txt = {txt, units[i][7:0]};
      end else begin
        txt = {txt, units[i][7:0]};
        txt = {txt, units[i][15:8]};
      end
    end
    if ($urandom_range(7) == 0) txt = {txt, 8'($urandom)};
    send_text(txt);
  endtask

  task automatic byte_text();
    logic [7:0] txt[$];
    repeat ($urandom_range(1, 10)) txt = {txt, 8'($urandom)};
    send_text(txt);
  endtask

  initial begin
    mode_e phase_modes[8];
    int    start;
    phase_modes = '{MODE_UTF16LE, MODE_UTF16BE, MODE_EIGHTBIT, MODE_PASS,
                    MODE_UTF16BE, MODE_UTF16LE, MODE_PASS, MODE_EIGHTBIT};
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    in_w.valid       = 1'b0;
    in_w.in_byte     = '0;
    in_w.end_of_text = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: surrogate pair, unchecked join, lone high at end, odd byte
    write_mode(MODE_UTF16LE);
    send_word(8'h3D, 1'b0); send_word(8'hD8, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'hDE, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'hD8, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'hDB, 1'b1);
    send_word(8'h3D, 1'b0); send_word(8'hD8, 1'b0); send_word(8'h55, 1'b1);
    send_word(8'hFF, 1'b0); send_word(8'hDB, 1'b1);
    // leave a high surrogate and a half unit; the mode write drops both
    send_word(8'h3D, 1'b0); send_word(8'hD8, 1'b0); send_word(8'h41, 1'b0);
    drain();
    write_mode(MODE_UTF16BE);
    send_word(8'hDB, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'hDF, 1'b0); send_word(8'hFF, 1'b1);
    drain();
    write_mode(MODE_EIGHTBIT);
    send_word(8'h7F, 1'b0); send_word(8'h80, 1'b0); send_word(8'hFF, 1'b1);
    drain();
    write_mode(MODE_PASS);
    send_word(8'h00, 1'b0); send_word(8'hFF, 1'b1);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_mode(phase_modes[p]);
      if (p < 3) begin
        tx_idle_pct <= 26;
        rx_idle_pct <= 59;
      end else if (p < 6) begin
        tx_idle_pct <= 59;
        rx_idle_pct <= 26;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      if (p == 6) hold_req <= 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        if ($urandom_range(9) < 8) begin
          case (phase_modes[p])
            MODE_UTF16LE:  utf16_text(1'b0);
            MODE_UTF16BE:  utf16_text(1'b1);
            default:       byte_text();
          endcase
        end else begin
          repeat ($urandom_range(1, 4))
            send_word(8'($urandom), $urandom_range(3) == 0);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
